/* src/vtyp_pkg.sv */
`default_nettype none
package vtyp_pkg;

	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_COORD_BITS    = 24;
	localparam int MAX_STAGES        = 24;
	localparam int GUARD             = 24;
	localparam int ANG_W             = 28;
	localparam int OUT_W             = ANG_W - 9;
	localparam int YAW_W             = 17;
	localparam int PITCH_W           = 15;
	localparam int KGAIN_W           = 26;

	localparam logic signed [KGAIN_W-1:0] KGAIN  = 26'sd27628053;
	localparam logic signed [ANG_W-1:0]   DEG90  = 28'sd5898240;
	localparam logic signed [ANG_W-1:0]   DEG180 = 28'sd11796480;
	localparam logic signed [ANG_W-1:0]   ROUND_HALF = 28'sd256;
	localparam logic signed [OUT_W-1:0]   ANG_LIMIT  = 19'sd11520;
	localparam logic signed [OUT_W-1:0]   YAW_HIGH   = 19'sd34560;

	// per-word flags that ride along the pipeline
	typedef struct packed {
		logic degen;
		logic vert;
		logic zneg;
		logic inactive;
	} vtyp_flags_t;

	// atan(2^-i) in degrees times 65536, rounded
	function automatic logic signed [ANG_W-1:0] atan_q16(input int i);
		logic signed [ANG_W-1:0] r;
		begin
			unique case (i)
				0: r = 28'sd2949120;
				1: r = 28'sd1740967;
				2: r = 28'sd919879;
				3: r = 28'sd466945;
				4: r = 28'sd234379;
				5: r = 28'sd117304;
				6: r = 28'sd58666;
				7: r = 28'sd29335;
				8: r = 28'sd14668;
				9: r = 28'sd7334;
				10: r = 28'sd3667;
				11: r = 28'sd1833;
				12: r = 28'sd917;
				13: r = 28'sd458;
				14: r = 28'sd229;
				15: r = 28'sd115;
				16: r = 28'sd57;
				17: r = 28'sd29;
				18: r = 28'sd14;
				19: r = 28'sd7;
				20: r = 28'sd4;
				21: r = 28'sd2;
				22: r = 28'sd1;
				default: r = 28'sd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

/* src/vector_to_yaw_pitch.sv */
// pipeline: difference register, prerotation register, yaw cordic stages, pitch cordic stages, output register
// throughput: one word per cycle; one cordic stage, yaw or pitch, per register level
// the whole pipeline holds while a finished word waits at the output register
// reset: arst_n clears all valid bits asynchronously; payload registers are not reset
`default_nettype none
module vector_to_yaw_pitch
	import vtyp_pkg::*;
#(
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
	parameter int COORD_BITS    = DEF_COORD_BITS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [COORD_BITS-1:0] source_x,
	input  wire logic signed [COORD_BITS-1:0] source_y,
	input  wire logic signed [COORD_BITS-1:0] source_z,
	input  wire logic signed [COORD_BITS-1:0] target_x,
	input  wire logic signed [COORD_BITS-1:0] target_y,
	input  wire logic signed [COORD_BITS-1:0] target_z,
	input  wire logic                         target_inactive,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [YAW_W-1:0]           yaw_angle,
	output logic signed [PITCH_W-1:0]         pitch_angle,
	output logic                              apply_flag,
	output logic                              degenerate_flag
);

	localparam int N  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
	localparam int DW = COORD_BITS + 1;
	localparam int W  = DW + GUARD + 4;
	localparam int PW = DW + KGAIN_W;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// difference stage
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic                 inact_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= DW'(target_x) - DW'(source_x);
			dy_s1    <= DW'(target_y) - DW'(source_y);
			dz_s1    <= DW'(target_z) - DW'(source_z);
			inact_s1 <= target_inactive;
		end
	end

	// prerotation into the right half plane, pitch operand scaling
	logic signed [W-1:0]  x0, y0;
	logic signed [ANG_W-1:0] z0;
	logic signed [PW-1:0] pm0;
	vtyp_flags_t          f0;

	always_comb begin
		x0 = W'(dx_s1) <<< GUARD;
		y0 = W'(dy_s1) <<< GUARD;
		z0 = '0;
		if (dx_s1 < 0) begin
			x0 = -x0;
			y0 = -y0;
			z0 = (dy_s1 >= 0) ? DEG180 : -DEG180;
		end
		pm0 = PW'(dz_s1) * PW'(KGAIN);
		f0.vert     = (dx_s1 == '0) && (dy_s1 == '0);
		f0.degen    = f0.vert && (dz_s1 == '0);
		f0.zneg     = dz_s1 < 0;
		f0.inactive = inact_s1;
	end

	// yaw cordic pipeline
	logic                    yv [0:N];
	logic signed [W-1:0]     yx [0:N];
	logic signed [W-1:0]     yy [0:N];
	logic signed [ANG_W-1:0] yz [0:N];
	logic signed [W-1:0]     ym [0:N];
	vtyp_flags_t             yf [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yv[0] <= 1'b0;
		end else if (en) begin
			yv[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yx[0] <= x0;
			yy[0] <= y0;
			yz[0] <= z0;
			ym[0] <= W'(pm0);
			yf[0] <= f0;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_yaw
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				yv[k+1] <= 1'b0;
			end else if (en) begin
				yv[k+1] <= yv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (yy[k] < 0) begin
					yx[k+1] <= yx[k] - (yy[k] >>> k);
					yy[k+1] <= yy[k] + (yx[k] >>> k);
					yz[k+1] <= yz[k] - atan_q16(k);
				end else begin
					yx[k+1] <= yx[k] + (yy[k] >>> k);
					yy[k+1] <= yy[k] - (yx[k] >>> k);
					yz[k+1] <= yz[k] + atan_q16(k);
				end
				ym[k+1] <= ym[k];
				yf[k+1] <= yf[k];
			end
		end
	end

	// pitch cordic pipeline, fed by the yaw magnitude
	logic                    pv [0:N];
	logic signed [W-1:0]     px [0:N];
	logic signed [W-1:0]     py [0:N];
	logic signed [ANG_W-1:0] pz [0:N];
	logic signed [ANG_W-1:0] pa [0:N];
	vtyp_flags_t             pf [0:N];

	assign pv[0] = yv[N];
	assign px[0] = yx[N];
	assign py[0] = ym[N];
	assign pz[0] = '0;
	assign pa[0] = yz[N];
	assign pf[0] = yf[N];

	for (genvar k = 0; k < N; k++) begin : g_pitch
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				pv[k+1] <= 1'b0;
			end else if (en) begin
				pv[k+1] <= pv[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (py[k] < 0) begin
					px[k+1] <= px[k] - (py[k] >>> k);
					py[k+1] <= py[k] + (px[k] >>> k);
					pz[k+1] <= pz[k] - atan_q16(k);
				end else begin
					px[k+1] <= px[k] + (py[k] >>> k);
					py[k+1] <= py[k] - (px[k] >>> k);
					pz[k+1] <= pz[k] + atan_q16(k);
				end
				pa[k+1] <= pa[k];
				pf[k+1] <= pf[k];
			end
		end
	end

	// rounding, saturation and special cases
	logic signed [ANG_W-1:0] yaw_acc;
	logic signed [OUT_W-1:0] yaw_r, pitch_r, yaw_o, pitch_o;

	always_comb begin
		yaw_acc = pa[N] + DEG90 + ROUND_HALF;
		yaw_r   = OUT_W'(yaw_acc >>> 9);
		pitch_r = OUT_W'((pz[N] + ROUND_HALF) >>> 9);
		if (yaw_r < -ANG_LIMIT) begin
			yaw_o = -ANG_LIMIT;
		end else if (yaw_r > YAW_HIGH) begin
			yaw_o = YAW_HIGH;
		end else begin
			yaw_o = yaw_r;
		end
		if (pitch_r < -ANG_LIMIT) begin
			pitch_o = -ANG_LIMIT;
		end else if (pitch_r > ANG_LIMIT) begin
			pitch_o = ANG_LIMIT;
		end else begin
			pitch_o = pitch_r;
		end
		if (pf[N].degen) begin
			yaw_o   = '0;
			pitch_o = '0;
		end else if (pf[N].vert) begin
			yaw_o   = DEG90[ANG_W-1:9];
			pitch_o = pf[N].zneg ? -ANG_LIMIT : ANG_LIMIT;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= pv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_angle       <= YAW_W'(yaw_o);
			pitch_angle     <= PITCH_W'(pitch_o);
			apply_flag      <= !pf[N].degen && !pf[N].inactive;
			degenerate_flag <= pf[N].degen;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
